// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define MFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also runs during reset
`define MFA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/mfa_pkg.sv =====
// shared types and constants of the mixed fraction unit
package mfa_pkg;

    localparam int WHOLE_OUT_BITS = 34;
    localparam int FRAC_BITS      = 33;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    typedef enum logic [2:0] {
        MS_PA,
        MS_PB,
        MS_X,
        MS_Y,
        MS_Z
    } t_msel;

    typedef enum logic [1:0] {
        DS_MAIN,
        DS_NUM,
        DS_DEN
    } t_dsel;

    typedef struct packed {
        logic  load;
        logic  mul_en;
        t_msel msel;
        logic  sign_en;
        logic  div_start;
        t_dsel dsel;
        logic  main_save;
        logic  gcd_step;
        logic  num_save;
        logic  den_save;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic div_zero;
        logic rem_zero;
        logic div_done;
        logic gcd_done;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/mixed_fraction_alu.sv =====
// top level: exact add, subtract, multiply and divide of two mixed fractions
// the divider runs for the quotient, then after the binary gcd steps for the reduced
// numerator and denominator; a remainder of zero skips the gcd and the last two runs
// one item at a time: the next item is taken at the earliest in the cycle after the result loads
// a zero denominator or a zero divisor skips the divider; a stalled result holds off the input
// synchronous active-low reset clears the state machine, divider count and output valid
module mixed_fraction_alu #(
    parameter int OPERAND_BITS = 12
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [OPERAND_BITS-1:0]            i_whole_a,
    input  logic        [OPERAND_BITS-2:0]            i_num_a,
    input  logic        [OPERAND_BITS-2:0]            i_den_a,
    input  logic        [1:0]                         i_func,
    input  logic signed [OPERAND_BITS-1:0]            i_whole_b,
    input  logic        [OPERAND_BITS-2:0]            i_num_b,
    input  logic        [OPERAND_BITS-2:0]            i_den_b,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [mfa_pkg::WHOLE_OUT_BITS-1:0] o_whole_out,
    output logic        [mfa_pkg::FRAC_BITS-1:0]      o_frac_num,
    output logic        [mfa_pkg::FRAC_BITS-1:0]      o_frac_den,
    output logic                                      o_negative,
    output logic                                      o_div_by_zero
);

    mfa_pkg::t_cmd    cmd;
    mfa_pkg::t_status status;

    mfa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_stall)
    );

    mfa_dp #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_whole_a     (i_whole_a),
        .i_num_a       (i_num_a),
        .i_den_a       (i_den_a),
        .i_func        (i_func),
        .i_whole_b     (i_whole_b),
        .i_num_b       (i_num_b),
        .i_den_b       (i_den_b),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_whole_out   (o_whole_out),
        .o_frac_num    (o_frac_num),
        .o_frac_den    (o_frac_den),
        .o_negative    (o_negative),
        .o_div_by_zero (o_div_by_zero)
    );

endmodule

// ===== rtl/mfa_ctrl.sv =====
// sequencing state machine of the mixed fraction unit
module mfa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mfa_pkg::t_status i_status,
    output mfa_pkg::t_cmd    o_cmd,
    output logic            o_busy
);

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_PA   = 15'h0002,
        S_PB   = 15'h0004,
        S_MX   = 15'h0008,
        S_MY   = 15'h0010,
        S_MZ   = 15'h0020,
        S_SIGN = 15'h0040,
        S_LD1  = 15'h0080,
        S_DV1  = 15'h0100,
        S_GCD  = 15'h0200,
        S_LD2  = 15'h0400,
        S_DV2  = 15'h0800,
        S_LD3  = 15'h1000,
        S_DV3  = 15'h2000,
        S_FIN  = 15'h4000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.den_zero ? S_FIN : S_PA;
                end
            end
            S_PA: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = mfa_pkg::MS_PA;
                n_state      = S_PB;
            end
            S_PB: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = mfa_pkg::MS_PB;
                n_state      = S_MX;
            end
            S_MX: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = mfa_pkg::MS_X;
                n_state      = S_MY;
            end
            S_MY: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = mfa_pkg::MS_Y;
                n_state      = S_MZ;
            end
            S_MZ: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = mfa_pkg::MS_Z;
                n_state      = S_SIGN;
            end
            S_SIGN: begin
                o_cmd.sign_en = 1'b1;
                n_state       = i_status.div_zero ? S_FIN : S_LD1;
            end
            S_LD1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.dsel      = mfa_pkg::DS_MAIN;
                n_state         = S_DV1;
            end
            S_DV1: begin
                if (i_status.div_done) begin
                    o_cmd.main_save = 1'b1;
                    n_state         = i_status.rem_zero ? S_FIN : S_GCD;
                end
            end
            S_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_status.gcd_done) begin
                    n_state = S_LD2;
                end
            end
            S_LD2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.dsel      = mfa_pkg::DS_NUM;
                n_state         = S_DV2;
            end
            S_DV2: begin
                if (i_status.div_done) begin
                    o_cmd.num_save = 1'b1;
                    n_state        = S_LD3;
                end
            end
            S_LD3: begin
                o_cmd.div_start = 1'b1;
                o_cmd.dsel      = mfa_pkg::DS_DEN;
                n_state         = S_DV3;
            end
            S_DV3: begin
                if (i_status.div_done) begin
                    o_cmd.den_save = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/mfa_dp.sv =====
// datapath: shared multiplier, bit-serial divider, binary gcd and result register
module mfa_dp #(
    parameter int OPERAND_BITS = 12
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  mfa_pkg::t_cmd                              i_cmd,
    output mfa_pkg::t_status                           o_status,
    input  logic signed [OPERAND_BITS-1:0]            i_whole_a,
    input  logic        [OPERAND_BITS-2:0]            i_num_a,
    input  logic        [OPERAND_BITS-2:0]            i_den_a,
    input  logic        [1:0]                         i_func,
    input  logic signed [OPERAND_BITS-1:0]            i_whole_b,
    input  logic        [OPERAND_BITS-2:0]            i_num_b,
    input  logic        [OPERAND_BITS-2:0]            i_den_b,
    input  logic                                      i_stall,
    output logic                                      o_valid,
    output logic signed [mfa_pkg::WHOLE_OUT_BITS-1:0] o_whole_out,
    output logic        [mfa_pkg::FRAC_BITS-1:0]      o_frac_num,
    output logic        [mfa_pkg::FRAC_BITS-1:0]      o_frac_den,
    output logic                                      o_negative,
    output logic                                      o_div_by_zero
);

    localparam int W  = OPERAND_BITS;
    localparam int FW = W - 1;
    localparam int MW = 2 * W;
    localparam int PW = 4 * W;
    localparam int CW = $clog2(PW + 1);

    logic signed [W-1:0]  r_wa;
    logic        [FW-1:0] r_na;
    logic        [FW-1:0] r_da;
    logic signed [W-1:0]  r_wb;
    logic        [FW-1:0] r_nb;
    logic        [FW-1:0] r_db;
    logic        [1:0]    r_func;

    logic signed [MW-1:0] r_pa;
    logic signed [MW-1:0] r_pb;
    logic signed [PW-1:0] r_x;
    logic signed [PW-1:0] r_y;
    logic signed [PW-1:0] r_z;

    logic        [PW-1:0] r_mag;
    logic        [PW-1:0] r_q;
    logic                 r_neg;
    logic                 r_err;

    logic        [PW-1:0] r_dvd;
    logic        [PW-1:0] r_dvs;
    logic        [PW-1:0] r_drem;
    logic        [CW-1:0] r_cnt;

    logic        [PW-1:0] r_whole;
    logic        [PW-1:0] r_r;
    logic        [PW-1:0] r_fn;
    logic        [PW-1:0] r_fd;
    logic        [PW-1:0] r_u;
    logic        [PW-1:0] r_v;
    logic        [CW-1:0] r_k;

    logic                 r_ovalid;

    logic signed [MW-1:0] m_a;
    logic signed [MW-1:0] m_b;
    logic signed [PW-1:0] prod;
    logic signed [MW-1:0] frac_adj;

    logic signed [PW-1:0] p_val;
    logic        [PW-1:0] q_val;
    logic                 div_zero;

    logic        [PW:0]   d_t;
    logic        [PW:0]   d_sub;
    logic                 d_ge;
    logic        [PW-1:0] ld_dvd;
    logic        [PW-1:0] ld_dvs;

    logic        [PW-1:0] gcd_val;
    logic        [PW-1:0] n_u;
    logic        [PW-1:0] n_v;
    logic        [CW-1:0] n_k;

    logic        [63:0]   whole_ext;
    logic        [63:0]   whole_sgn;
    logic        [63:0]   fn_ext;
    logic        [63:0]   fd_ext;

    // operand select for the shared multiplier
    always_comb begin
        m_a      = r_pa;
        m_b      = r_pb;
        frac_adj = '0;
        case (i_cmd.msel)
            mfa_pkg::MS_PA: begin
                m_a      = MW'(r_wa);
                m_b      = MW'({1'b0, r_da});
                frac_adj = r_wa[W-1] ? -MW'({1'b0, r_na}) : MW'({1'b0, r_na});
            end
            mfa_pkg::MS_PB: begin
                m_a      = MW'(r_wb);
                m_b      = MW'({1'b0, r_db});
                frac_adj = r_wb[W-1] ? -MW'({1'b0, r_nb}) : MW'({1'b0, r_nb});
            end
            mfa_pkg::MS_X: begin
                m_a = r_pa;
                m_b = (r_func == mfa_pkg::FUNC_MUL) ? r_pb : MW'({1'b0, r_db});
            end
            mfa_pkg::MS_Y: begin
                m_a = r_pb;
                m_b = MW'({1'b0, r_da});
            end
            mfa_pkg::MS_Z: begin
                m_a = MW'({1'b0, r_da});
                m_b = MW'({1'b0, r_db});
            end
            default: begin
                m_a = r_pa;
                m_b = r_pb;
            end
        endcase
    end

    assign prod = m_a * m_b;

    // combine products into signed numerator and positive denominator
    always_comb begin
        q_val = PW'(r_z);
        case (r_func)
            mfa_pkg::FUNC_ADD: p_val = r_x + r_y;
            mfa_pkg::FUNC_SUB: p_val = r_x - r_y;
            mfa_pkg::FUNC_MUL: p_val = r_x;
            mfa_pkg::FUNC_DIV: begin
                p_val = r_y[PW-1] ? -r_x : r_x;
                q_val = r_y[PW-1] ? PW'(-r_y) : PW'(r_y);
            end
            default: p_val = r_x;
        endcase
    end

    assign div_zero = (r_func == mfa_pkg::FUNC_DIV) && (r_pb == '0);

    // restoring divider, one quotient bit a cycle
    assign d_t   = {r_drem, r_dvd[PW-1]};
    assign d_sub = d_t - {1'b0, r_dvs};
    assign d_ge  = (d_t >= {1'b0, r_dvs});

    always_comb begin
        ld_dvd = r_mag;
        ld_dvs = r_q;
        case (i_cmd.dsel)
            mfa_pkg::DS_MAIN: begin
                ld_dvd = r_mag;
                ld_dvs = r_q;
            end
            mfa_pkg::DS_NUM: begin
                ld_dvd = r_r;
                ld_dvs = gcd_val;
            end
            mfa_pkg::DS_DEN: begin
                ld_dvd = r_q;
                ld_dvs = gcd_val;
            end
            default: begin
                ld_dvd = r_mag;
                ld_dvs = r_q;
            end
        endcase
    end

    // binary gcd step
    assign gcd_val = (r_u | r_v) << r_k;

    always_comb begin
        n_u = r_u;
        n_v = r_v;
        n_k = r_k;
        if (!r_u[0] && !r_v[0]) begin
            n_u = r_u >> 1;
            n_v = r_v >> 1;
            n_k = r_k + CW'(1);
        end else if (!r_u[0]) begin
            n_u = r_u >> 1;
        end else if (!r_v[0]) begin
            n_v = r_v >> 1;
        end else if (r_u >= r_v) begin
            n_u = r_u - r_v;
        end else begin
            n_v = r_v - r_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wa   <= i_whole_a;
            r_na   <= i_num_a;
            r_da   <= i_den_a;
            r_wb   <= i_whole_b;
            r_nb   <= i_num_b;
            r_db   <= i_den_b;
            r_func <= i_func;
            r_err  <= o_status.den_zero;
            r_neg  <= 1'b0;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.msel)
                mfa_pkg::MS_PA: r_pa <= MW'(prod) + frac_adj;
                mfa_pkg::MS_PB: r_pb <= MW'(prod) + frac_adj;
                mfa_pkg::MS_X:  r_x  <= prod;
                mfa_pkg::MS_Y:  r_y  <= prod;
                mfa_pkg::MS_Z:  r_z  <= prod;
                default:        r_z  <= prod;
            endcase
        end
        if (i_cmd.sign_en) begin
            r_err <= div_zero;
            r_neg <= p_val[PW-1] && !div_zero;
            r_mag <= p_val[PW-1] ? PW'(-p_val) : PW'(p_val);
            r_q   <= q_val;
        end
        if (i_cmd.div_start) begin
            r_dvd  <= ld_dvd;
            r_dvs  <= ld_dvs;
            r_drem <= '0;
        end else if (r_cnt != '0) begin
            r_drem <= d_ge ? d_sub[PW-1:0] : d_t[PW-1:0];
            r_dvd  <= {r_dvd[PW-2:0], d_ge};
        end
        if (i_cmd.main_save) begin
            r_whole <= r_dvd;
            r_r     <= r_drem;
            r_fn    <= '0;
            r_fd    <= PW'(1);
            r_u     <= r_drem;
            r_v     <= r_q;
            r_k     <= '0;
        end else if (i_cmd.gcd_step && !o_status.gcd_done) begin
            r_u <= n_u;
            r_v <= n_v;
            r_k <= n_k;
        end
        if (i_cmd.num_save) begin
            r_fn <= r_dvd;
        end
        if (i_cmd.den_save) begin
            r_fd <= r_dvd;
        end
        if (i_cmd.out_load) begin
            o_whole_out   <= r_err ? '0 : whole_sgn[mfa_pkg::WHOLE_OUT_BITS-1:0];
            o_frac_num    <= r_err ? '0 : fn_ext[mfa_pkg::FRAC_BITS-1:0];
            o_frac_den    <= r_err ? '0 : fd_ext[mfa_pkg::FRAC_BITS-1:0];
            o_negative    <= r_err ? 1'b0 : r_neg;
            o_div_by_zero <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.div_start) begin
                r_cnt <= CW'(PW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign whole_ext = 64'(r_whole);
    assign whole_sgn = r_neg ? (64'd0 - whole_ext) : whole_ext;
    assign fn_ext    = 64'(r_fn);
    assign fd_ext    = 64'(r_fd);

    assign o_status.den_zero = (i_den_a == '0) || (i_den_b == '0);
    assign o_status.div_zero = div_zero;
    assign o_status.rem_zero = (r_drem == '0);
    assign o_status.div_done = (r_cnt == '0);
    assign o_status.gcd_done = (r_u == '0) || (r_v == '0);
    assign o_status.out_free = !r_ovalid || !i_stall;

    assign o_valid = r_ovalid;

endmodule

// ===== rtl/mfa_checker.sv =====
// port-level checker of the mixed fraction unit and its bind
`include "assert_macros.svh"

module mfa_checker (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      o_valid,
    input logic                                      i_stall,
    input logic signed [mfa_pkg::WHOLE_OUT_BITS-1:0] o_whole_out,
    input logic        [mfa_pkg::FRAC_BITS-1:0]      o_frac_num,
    input logic        [mfa_pkg::FRAC_BITS-1:0]      o_frac_den,
    input logic                                      o_negative,
    input logic                                      o_div_by_zero
);

    `MFA_ASSERT(a_err_clear, o_valid && o_div_by_zero |-> o_whole_out == '0 && o_frac_num == '0 && o_frac_den == '0 && !o_negative, "error item carries non-zero fields")
    `MFA_ASSERT(a_zero_frac, o_valid && !o_div_by_zero && o_frac_num == '0 |-> o_frac_den == 33'd1, "zero fraction without unit denominator")
    `MFA_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_whole_out) && $stable(o_frac_num) && $stable(o_frac_den), "stalled item changed")
    `MFA_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_valid, "item shown after reset")

endmodule

bind mixed_fraction_alu mfa_checker u_mfa_checker (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the mixed fraction unit: random and directed items, scored
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OB        = 12;
    localparam int WOB       = mfa_pkg::WHOLE_OUT_BITS;
    localparam int FB        = mfa_pkg::FRAC_BITS;
    localparam int WDOG_MAX  = 3000;
    localparam int TAIL_WAIT = 300;
    localparam int N_RANDOM  = 630;

    typedef struct {
        logic signed [OB-1:0] whole_a;
        logic        [OB-2:0] num_a;
        logic        [OB-2:0] den_a;
        logic        [1:0]    func;
        logic signed [OB-1:0] whole_b;
        logic        [OB-2:0] num_b;
        logic        [OB-2:0] den_b;
        bit                   drain;
    } t_operand_pair;

    typedef struct {
        logic signed [WOB-1:0] whole;
        logic        [FB-1:0]  num;
        logic        [FB-1:0]  den;
        logic                  neg;
        logic                  dbz;
    } t_fraction;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic signed [OB-1:0]  i_whole_a = '0;
    logic        [OB-2:0]  i_num_a = '0;
    logic        [OB-2:0]  i_den_a = 11'd1;
    logic        [1:0]     i_func = mfa_pkg::FUNC_ADD;
    logic signed [OB-1:0]  i_whole_b = '0;
    logic        [OB-2:0]  i_num_b = '0;
    logic        [OB-2:0]  i_den_b = 11'd1;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [WOB-1:0] o_whole_out;
    logic        [FB-1:0]  o_frac_num;
    logic        [FB-1:0]  o_frac_den;
    logic                  o_negative;
    logic                  o_div_by_zero;

    t_operand_pair pending_items[$];
    t_fraction     expected_fractions[$];
    int            mismatches = 0;
    int            items_sent = 0;
    int            results_seen = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    int            idle_cycles = 0;

    mixed_fraction_alu #(.OPERAND_BITS(OB)) u_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_fraction fraction_result(t_operand_pair it);
        t_fraction r;
        longint wa, na, da, wb, nb, db, pa, pb, p, q, mag, whole, rem, x, y, t;
        r = '{default: '0};
        wa = longint'(it.whole_a);
        na = longint'(it.num_a);
        da = longint'(it.den_a);
        wb = longint'(it.whole_b);
        nb = longint'(it.num_b);
        db = longint'(it.den_b);
        if (da == 0 || db == 0) begin
            r.dbz = 1'b1;
            return r;
        end
        pa = wa * da + ((wa < 0) ? -na : na);
        pb = wb * db + ((wb < 0) ? -nb : nb);
        case (it.func)
            mfa_pkg::FUNC_ADD: begin p = pa * db + pb * da; q = da * db; end
            mfa_pkg::FUNC_SUB: begin p = pa * db - pb * da; q = da * db; end
            mfa_pkg::FUNC_MUL: begin p = pa * pb;           q = da * db; end
            default: begin
                if (pb == 0) begin
                    r.dbz = 1'b1;
                    return r;
                end
                p = pa * db;
                q = da * pb;
                if (q < 0) begin
                    q = -q;
                    p = -p;
                end
            end
        endcase
        r.neg = (p < 0);
        mag = r.neg ? -p : p;
        whole = mag / q;
        rem = mag % q;
        r.whole = WOB'(r.neg ? -whole : whole);
        if (rem == 0) begin
            r.den = FB'(1);
        end else begin
            x = q;
            y = rem;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            r.num = FB'(rem / x);
            r.den = FB'(q / x);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (items_sent >= 250 && items_sent < 350)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, field, got,
                 want);
        mismatches++;
    endtask

    task automatic add_item(int wa, int na, int da, logic [1:0] f, int wb, int nb, int db);
        t_operand_pair it;
        it.whole_a = OB'(wa);
        it.num_a = (OB-1)'(na);
        it.den_a = (OB-1)'(da);
        it.func = f;
        it.whole_b = OB'(wb);
        it.num_b = (OB-1)'(nb);
        it.den_b = (OB-1)'(db);
        it.drain = 1'b0;
        pending_items.push_back(it);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_operand_pair it;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                it.whole_a = i_whole_a;
                it.num_a = i_num_a;
                it.den_a = i_den_a;
                it.func = i_func;
                it.whole_b = i_whole_b;
                it.num_b = i_num_b;
                it.den_b = i_den_b;
                it.drain = 1'b0;
                expected_fractions.push_back(fraction_result(it));
                items_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !(pending_items[0].drain &&
                             expected_fractions.size() > 0)) begin
                    it = pending_items.pop_front();
                    i_whole_a <= it.whole_a;
                    i_num_a <= it.num_a;
                    i_den_a <= it.den_a;
                    i_func <= it.func;
                    i_whole_b <= it.whole_b;
                    i_num_b <= it.num_b;
                    i_den_b <= it.den_b;
                    i_valid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_fractions.size() == 0) begin
                    report_mismatch("items outstanding", 0, 1);
                end else begin
                    want = expected_fractions.pop_front();
                    if (o_whole_out !== want.whole)
                        report_mismatch("whole_out", longint'(o_whole_out),
                                        longint'(want.whole));
                    if (o_frac_num !== want.num)
                        report_mismatch("frac_num", longint'(o_frac_num), longint'(want.num));
                    if (o_frac_den !== want.den)
                        report_mismatch("frac_den", longint'(o_frac_den), longint'(want.den));
                    if (o_negative !== want.neg)
                        report_mismatch("negative", longint'(o_negative), longint'(want.neg));
                    if (o_div_by_zero !== want.dbz)
                        report_mismatch("div_by_zero", longint'(o_div_by_zero),
                                        longint'(want.dbz));
                end
                results_seen++;
            end
            if (!hold_done && results_seen >= 120) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("mixed_fraction_alu verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_operand_pair it;
        int r;
        add_item(0, 0, 1, mfa_pkg::FUNC_ADD, 0, 0, 1);
        add_item(-2048, 2047, 2047, mfa_pkg::FUNC_ADD, -2048, 2047, 2047);
        add_item(2047, 2047, 1, mfa_pkg::FUNC_SUB, -2048, 2047, 1);
        add_item(2047, 2047, 2047, mfa_pkg::FUNC_MUL, 2047, 2047, 2047);
        add_item(-2048, 2047, 1, mfa_pkg::FUNC_MUL, 2047, 2047, 1);
        add_item(-2048, 2047, 2047, mfa_pkg::FUNC_MUL, -2048, 2047, 2047);
        add_item(2047, 2047, 1, mfa_pkg::FUNC_DIV, 0, 1, 2047);
        add_item(-2048, 0, 1, mfa_pkg::FUNC_DIV, 2047, 1, 3);
        add_item(5, 1, 2, mfa_pkg::FUNC_DIV, 0, 0, 7);
        add_item(0, 0, 1, mfa_pkg::FUNC_DIV, 0, 0, 1);
        add_item(3, 1, 4, mfa_pkg::FUNC_ADD, 1, 2, 0);
        add_item(3, 1, 0, mfa_pkg::FUNC_MUL, 1, 2, 3);
        add_item(0, 1, 2, mfa_pkg::FUNC_SUB, 0, 3, 4);
        add_item(-1, 1, 3, mfa_pkg::FUNC_ADD, 1, 0, 1);
        add_item(0, 1, 3, mfa_pkg::FUNC_MUL, -1, 0, 1);
        add_item(7, 3, 5, mfa_pkg::FUNC_SUB, 7, 3, 5);
        add_item(-4, 2, 6, mfa_pkg::FUNC_ADD, 4, 1, 3);
        add_item(1, 1, 2, mfa_pkg::FUNC_DIV, -3, 0, 1);
        add_item(-1, 2047, 2047, mfa_pkg::FUNC_DIV, 1, 2046, 2047);
        add_item(1024, 1024, 1024, mfa_pkg::FUNC_ADD, -1, 1, 1);
        for (int n = 0; n < N_RANDOM; n++) begin
            it.whole_a = OB'($urandom);
            it.num_a = (OB-1)'($urandom);
            it.den_a = (OB-1)'($urandom);
            it.func = 2'($urandom);
            it.whole_b = OB'($urandom);
            it.num_b = (OB-1)'($urandom);
            it.den_b = (OB-1)'($urandom);
            it.drain = (n == 400);
            r = int'($urandom_range(0, 99));
            if (r < 30) begin
                it.whole_a = OB'(int'($urandom_range(0, 30)) - 15);
                it.whole_b = OB'(int'($urandom_range(0, 30)) - 15);
                it.den_a = (OB-1)'($urandom_range(1, 40));
                it.den_b = (OB-1)'($urandom_range(1, 40));
                it.num_a = (OB-1)'($urandom_range(0, 32'(it.den_a)));
                it.num_b = (OB-1)'($urandom_range(0, 32'(it.den_b)));
            end else if (r < 34) begin
                it.den_a = '0;
            end else if (r < 38) begin
                it.den_b = '0;
            end else if (r < 44) begin
                it.func = mfa_pkg::FUNC_DIV;
                it.whole_b = '0;
                it.num_b = '0;
            end
            if (it.den_a == '0 && r >= 34)
                it.den_a = (OB-1)'(1);
            if (it.den_b == '0 && (r < 34 || r >= 38))
                it.den_b = (OB-1)'(1);
            pending_items.push_back(it);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (pending_items.size() > 0 || i_valid || expected_fractions.size() > 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("mixed_fraction_alu verification clean");
        else
            $display("mixed_fraction_alu verification failed");
        $finish;
    end
endmodule
